// File: rtl/float64_modf_split_assert.svh
// assertion macros for the modf split block
`ifndef FLOAT64_MODF_SPLIT_ASSERT_SVH
`define FLOAT64_MODF_SPLIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FMS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMS_ASSERT(label, clk, rst_n, prop, msg)
`define FMS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/fms_pkg.sv
package fms_pkg;
  localparam int unsigned MantBits = 52;
  localparam int unsigned ExpBits = 11;
  localparam int unsigned ExpBias = 1023;
  localparam logic [ExpBits-1:0] ExpAllOne = 11'h7FF;
  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;

  typedef logic [63:0] f64_t;

  typedef struct packed {
    f64_t int_part;
    f64_t frac_part;
  } fms_res_t;
endpackage

// File: rtl/fms_core.sv
module fms_core (
  input  fms_pkg::f64_t     x_i,
  output fms_pkg::fms_res_t res_o
);
  import fms_pkg::*;

  logic                sign;
  logic [ExpBits-1:0]  exp_f;
  logic [MantBits-1:0] mant;
  logic [5:0]          fbits;
  logic [MantBits-1:0] low_mask;
  logic [MantBits-1:0] rest;
  logic [5:0]          top;
  logic [MantBits-1:0] norm;
  logic [ExpBits-1:0]  fexp;

  assign sign  = x_i[63];
  assign exp_f = x_i[62:MantBits];
  assign mant  = x_i[MantBits-1:0];
  // fraction bit count, valid for exponents 0..51 unbiased
  assign fbits = 6'(11'(ExpBias + MantBits) - exp_f);
  assign low_mask = (52'd1 << fbits) - 52'd1;
  assign rest = mant & low_mask;

  always_comb begin
    top = '0;
    for (int i = 0; i < MantBits; i++) begin
      if (rest[i]) top = 6'(i);
    end
  end

  assign norm = rest << (6'(MantBits) - top);
  // exponent of leading bit: top + exp_f - 52
  assign fexp = exp_f + 11'(top) - 11'(MantBits);

  always_comb begin
    if (exp_f == ExpAllOne && mant != '0) begin
      res_o.int_part  = {sign, QnanBits[62:0]};
      res_o.frac_part = {sign, QnanBits[62:0]};
    end else if (exp_f >= 11'(ExpBias + MantBits)) begin
      res_o.int_part  = x_i;
      res_o.frac_part = {sign, 63'd0};
    end else if (exp_f < 11'(ExpBias)) begin
      res_o.int_part  = {sign, 63'd0};
      res_o.frac_part = x_i;
    end else begin
      res_o.int_part = {x_i[63:MantBits], mant & ~low_mask};
      if (rest == '0) begin
        res_o.frac_part = {sign, 63'd0};
      end else begin
        res_o.frac_part = {sign, fexp, norm};
      end
    end
  end
endmodule

// File: rtl/float64_modf_split.sv
// input beat to result beat passes the input register, the core logic and the result register
// throughput: one beat per cycle, stalls propagate through a two-stage pipeline
// a stage advances whenever it is empty or the stage after it is empty or moving
// reset clears the valid flags only; the data registers are not reset
`include "float64_modf_split_assert.svh"
module float64_modf_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] x_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] int_part_bits_o,
  output logic [63:0] frac_part_bits_o
);
  import fms_pkg::*;

  logic     in_vld_q, out_vld_q;
  f64_t     x_q;
  fms_res_t res_d, res_q;
  logic     out_adv, in_adv;

  assign out_adv = !out_vld_q || !stall_i;
  assign in_adv  = !in_vld_q || out_adv;
  assign stall_o = !in_adv;

  fms_core u_core (
    .x_i  (x_q),
    .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= valid_i;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && valid_i) x_q <= x_bits_i;
    if (out_adv && in_vld_q) res_q <= res_d;
  end

  assign valid_o          = out_vld_q;
  assign int_part_bits_o  = res_q.int_part;
  assign frac_part_bits_o = res_q.frac_part;

  `FMS_ASSERT(a_out_hold, clk_i, rst_ni, out_vld_q && stall_i |=> out_vld_q && $stable(res_q), "result changed under stall")
  `FMS_ASSERT(a_stall_full, clk_i, rst_ni, stall_o |-> in_vld_q && out_vld_q, "stall without full pipe")
  `FMS_ASSERT(a_move, clk_i, rst_ni, in_vld_q && !stall_o && (!out_vld_q || !stall_i) |=> out_vld_q, "beat lost between stages")
  `FMS_ASSERT_RST(a_rst, clk_i, !rst_ni |=> !valid_o, "valid during reset")
endmodule
